### hdl/trk_pkg.sv
// ----------------------------------------------------------------------------
// Trackball drag rotation package
// Shared types, codes and constants for the trackball rotation datapath.
// ----------------------------------------------------------------------------
package trk_pkg;

  localparam int COORD_BITS   = 12;
  localparam int FRAC_BITS    = 14;
  localparam int CORDIC_STEPS = 16;

  localparam logic [1:0] FN_PRESS   = 2'd0;
  localparam logic [1:0] FN_RELEASE = 2'd1;
  localparam logic [1:0] FN_MOVE    = 2'd2;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  localparam logic [15:0] AXIS_ONE  = 16'd16384;
  localparam logic [15:0] ANGLE_MAX = 16'd46080;
  localparam logic signed [26:0] ANGLE_LIM = 27'sd5898240;
  localparam logic [11:0] EPS_SUM   = 12'd720;

  localparam logic [6:0] NC_STEPS    = 7'd28;
  localparam logic [6:0] ZSPH_STEPS  = 7'd17;
  localparam logic [6:0] ZSHT_STEPS  = 7'd18;
  localparam logic [6:0] ZDIV_STEPS  = 7'd32;
  localparam logic [6:0] LEN_STEPS   = 7'd32;
  localparam logic [6:0] AXDIV_STEPS = 7'd45;
  localparam logic [6:0] ANG_STEPS   = 7'd21;

  typedef logic signed [19:0] coord_t;

  typedef enum logic {
    OP_DIV,
    OP_SQRT
  } it_op_t;

  typedef struct packed {
    logic        start;
    it_op_t      op;
    logic [6:0]  steps;
    logic [63:0] arg;
    logic [31:0] divisor;
  } it_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } it_rsp_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_NX, ST_NXW, ST_NY, ST_NYW, ST_N2A, ST_N2B, ST_N2C,
    ST_ZSEL, ST_ZSPW, ST_ZSHS, ST_ZSHV, ST_ZSHD, ST_EVAL,
    ST_C0A, ST_C0B, ST_C1A, ST_C1B, ST_C2A, ST_C2B, ST_C2C,
    ST_DEG, ST_NRM, ST_SQ0, ST_SQ1, ST_SQ2, ST_SQ3, ST_LENS, ST_LENW,
    ST_AXD, ST_AXW, ST_G0, ST_G1, ST_G2, ST_G3, ST_G4, ST_G5,
    ST_GY, ST_GXS, ST_GX, ST_GN, ST_CRD, ST_GFIN, ST_FIN
  } state_t;

  function automatic logic signed [26:0] atan_tab(input logic [3:0] i);
    logic signed [26:0] v;
    case (i)
      4'd0:  v = 27'sd2949120;
      4'd1:  v = 27'sd1740967;
      4'd2:  v = 27'sd919879;
      4'd3:  v = 27'sd466945;
      4'd4:  v = 27'sd234379;
      4'd5:  v = 27'sd117304;
      4'd6:  v = 27'sd58666;
      4'd7:  v = 27'sd29335;
      4'd8:  v = 27'sd14668;
      4'd9:  v = 27'sd7334;
      4'd10: v = 27'sd3667;
      4'd11: v = 27'sd1833;
      4'd12: v = 27'sd917;
      4'd13: v = 27'sd458;
      4'd14: v = 27'sd229;
      default: v = 27'sd115;
    endcase
    return v;
  endfunction

endpackage

### hdl/trackball_drag_rotation.sv
// ----------------------------------------------------------------------------
// Trackball drag rotation
// Maps pointer events onto a virtual trackball and returns drag rotations.
//
// Requests arrive on the s_ channel: s_tuser holds the event kind (press,
// release, move with button held), s_tdata the pointer column and row. Each
// request gives exactly one result on the m_ channel: m_tuser is the
// rotation flag, m_tdata the unit axis (Q1.14) and the angle (Q8.8 degrees).
// Results of non-rotating events are all zero.
// The block takes one request at a time and is not ready while it works.
// Processing: a release or unknown kind goes straight to the result; a press
// or a move without rotation maps the point onto the sphere, or onto the
// sheet with one more division; a rotating move also finds axis and angle,
// and a degenerate axis with no motion skips the axis divisions and the
// angle loop. The processing time is set by the shared divide / square root
// unit, which yields one quotient or root bit per cycle, by the operand
// normalization loops and by the 16-step angle rotation loop.
// The configuration channel writes width, height and radius; it is always
// ready. Reset restores default configuration and disarms the block.
// A stalled receiver holds the result in the output register; the next
// request is taken meanwhile and waits at its end until the slot frees.
// ----------------------------------------------------------------------------
module trackball_drag_rotation import trk_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // cursor_x [11:0], cursor_y [23:12]
  input  logic [1:0]  s_tuser,  // func [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,  // axis_x [15:0], axis_y [31:16], axis_z [47:32],
                                // angle_deg [63:48]
  output logic        m_tuser   // rotation_valid [0]
);

  state_t state, state_next;

  logic [11:0] scr_w, scr_h;
  logic [15:0] radius;
  logic [11:0] w_eff, h_eff;
  logic [15:0] r_eff;

  logic [1:0]  func_r;
  logic [11:0] cx_r, cy_r;
  logic        armed;
  coord_t      ax, ay, az, bx, by, bz;
  logic        neg_r;
  logic [63:0] acc;
  logic [31:0] sroot;
  logic signed [35:0] c0, c1, c2;
  logic [35:0] m0, m1, m2;
  logic [31:0] len;
  logic [1:0]  ai;
  logic [63:0] dq, rq;
  logic signed [33:0] gx, gy;
  logic signed [26:0] gz;
  logic [3:0]  crd_i;
  logic        rv;
  logic [15:0] ox, oy, oz, oang;

  it_req_t itq;
  it_rsp_t itr;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;

  logic [11:0] nc_c, nc_s;
  logic signed [13:0] nc_diff;
  logic        nc_neg;
  logic [12:0] nc_mag;
  logic [63:0] nc_arg;
  logic [15:0] qsat;
  logic [19:0] nq;
  logic [63:0] half;
  logic [35:0] mg0, mg1, mg2, mx, msel;
  logic [9:0]  sq0, sq1, sq2;
  logic [11:0] sumsq;
  logic        deg;
  logic signed [31:0] d0, d1, d2;
  logic signed [33:0] gmx, xs, ys;
  logic [15:0] q16;
  logic [22:0] zc;
  logic [23:0] zr;
  logic        fin_go;

  trk_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));
  trk_iter u_iter (.clk(clk), .rst(rst), .req(itq), .rsp(itr));

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign w_eff     = (scr_w == 12'd0) ? 12'd1 : scr_w;
  assign h_eff     = (scr_h == 12'd0) ? 12'd1 : scr_h;
  assign r_eff     = (radius == 16'd0) ? 16'd1 : radius;
  assign half      = {33'd0, r_eff, 15'd0};
  assign fin_go    = !m_tvalid || m_tready;

  assign nc_c    = (state == ST_NY) ? cy_r : cx_r;
  assign nc_s    = (state == ST_NY) ? h_eff : w_eff;
  assign nc_diff = $signed({1'b0, nc_c, 1'b0}) - $signed({2'b0, nc_s});
  assign nc_neg  = nc_diff[13];
  assign nc_mag  = nc_neg ? 13'(-nc_diff) : nc_diff[12:0];
  assign nc_arg  = ({51'd0, nc_mag} << FRAC_BITS) + {53'd0, nc_s[11:1]};
  assign qsat    = (itr.result > 64'd65535) ? 16'hFFFF : itr.result[15:0];
  assign nq      = {4'd0, qsat};

  assign mg0   = c0[35] ? 36'(-c0) : c0;
  assign mg1   = c1[35] ? 36'(-c1) : c1;
  assign mg2   = c2[35] ? 36'(-c2) : c2;
  assign sq0   = mg0[4:0] * mg0[4:0];
  assign sq1   = mg1[4:0] * mg1[4:0];
  assign sq2   = mg2[4:0] * mg2[4:0];
  assign sumsq = {2'd0, sq0} + {2'd0, sq1} + {2'd0, sq2};
  assign deg   = (mg0[35:5] == '0) && (mg1[35:5] == '0) && (mg2[35:5] == '0) &&
                 (sumsq <= EPS_SUM);

  always_comb begin
    mx = (m0 > m1) ? m0 : m1;
    if (m2 > mx) mx = m2;
  end

  always_comb begin
    case (ai)
      2'd0:    msel = m0;
      2'd1:    msel = m1;
      default: msel = m2;
    endcase
  end

  assign d0  = 32'(ax) - 32'(bx);
  assign d1  = 32'(ay) - 32'(by);
  assign d2  = 32'(az) - 32'(bz);
  assign gmx = (gx > gy) ? gx : gy;
  assign xs  = gx >>> crd_i;
  assign ys  = gy >>> crd_i;
  assign q16 = itr.result[15:0];

  always_comb begin
    if (gz < 27'sd0) zc = '0;
    else if (gz > ANGLE_LIM) zc = ANGLE_LIM[22:0];
    else zc = gz[22:0];
  end
  assign zr = ({zc, 1'b0} + 24'd128) >> 8;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    itq   = '0;
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser inside {FN_PRESS, FN_MOVE}) state_next = ST_NX;
          else state_next = ST_FIN;
        end
      end
      ST_NX, ST_NY: begin
        itq.start   = 1'b1;
        itq.op      = OP_DIV;
        itq.steps   = NC_STEPS;
        itq.arg     = nc_arg;
        itq.divisor = {20'd0, nc_s};
        state_next  = (state == ST_NX) ? ST_NXW : ST_NYW;
      end
      ST_NXW: if (itr.done) state_next = ST_NY;
      ST_NYW: if (itr.done) state_next = ST_N2A;
      ST_N2A: begin
        mul_a = 32'(bx);
        mul_b = 32'(bx);
        state_next = ST_N2B;
      end
      ST_N2B: begin
        mul_a = 32'(by);
        mul_b = 32'(by);
        state_next = ST_N2C;
      end
      ST_N2C: state_next = ST_ZSEL;
      ST_ZSEL: begin
        itq.start = 1'b1;
        itq.op    = OP_SQRT;
        if (acc < half) begin
          itq.steps  = ZSPH_STEPS;
          itq.arg    = {32'd0, r_eff, 16'd0} - acc;
          state_next = ST_ZSPW;
        end else begin
          itq.steps  = ZSHT_STEPS;
          itq.arg    = acc;
          state_next = ST_ZSHS;
        end
      end
      ST_ZSPW: if (itr.done) state_next = ST_EVAL;
      ST_ZSHS: if (itr.done) state_next = ST_ZSHV;
      ST_ZSHV: begin
        itq.start   = 1'b1;
        itq.op      = OP_DIV;
        itq.steps   = ZDIV_STEPS;
        itq.arg     = half + {33'd0, sroot[31:1]};
        itq.divisor = sroot;
        state_next  = ST_ZSHD;
      end
      ST_ZSHD: if (itr.done) state_next = ST_EVAL;
      ST_EVAL: begin
        if (func_r == FN_MOVE && armed) state_next = ST_C0A;
        else state_next = ST_FIN;
      end
      ST_C0A: begin
        mul_a = 32'(ay);
        mul_b = 32'(bz);
        state_next = ST_C0B;
      end
      ST_C0B: begin
        mul_a = 32'(az);
        mul_b = 32'(by);
        state_next = ST_C1A;
      end
      ST_C1A: begin
        mul_a = 32'(az);
        mul_b = 32'(bx);
        state_next = ST_C1B;
      end
      ST_C1B: begin
        mul_a = 32'(ax);
        mul_b = 32'(bz);
        state_next = ST_C2A;
      end
      ST_C2A: begin
        mul_a = 32'(ax);
        mul_b = 32'(by);
        state_next = ST_C2B;
      end
      ST_C2B: begin
        mul_a = 32'(ay);
        mul_b = 32'(bx);
        state_next = ST_C2C;
      end
      ST_C2C: state_next = ST_DEG;
      ST_DEG: state_next = deg ? ST_G0 : ST_NRM;
      ST_NRM: if (mx[35:29] == 7'd1) state_next = ST_SQ0;
      ST_SQ0: begin
        mul_a = $signed({2'd0, m0[29:0]});
        mul_b = $signed({2'd0, m0[29:0]});
        state_next = ST_SQ1;
      end
      ST_SQ1: begin
        mul_a = $signed({2'd0, m1[29:0]});
        mul_b = $signed({2'd0, m1[29:0]});
        state_next = ST_SQ2;
      end
      ST_SQ2: begin
        mul_a = $signed({2'd0, m2[29:0]});
        mul_b = $signed({2'd0, m2[29:0]});
        state_next = ST_SQ3;
      end
      ST_SQ3: state_next = ST_LENS;
      ST_LENS: begin
        itq.start  = 1'b1;
        itq.op     = OP_SQRT;
        itq.steps  = LEN_STEPS;
        itq.arg    = acc;
        state_next = ST_LENW;
      end
      ST_LENW: if (itr.done) state_next = ST_AXD;
      ST_AXD: begin
        itq.start   = 1'b1;
        itq.op      = OP_DIV;
        itq.steps   = AXDIV_STEPS;
        itq.arg     = ({34'd0, msel[29:0]} << FRAC_BITS) + {33'd0, len[31:1]};
        itq.divisor = len;
        state_next  = ST_AXW;
      end
      ST_AXW: if (itr.done) state_next = (ai == 2'd2) ? ST_G0 : ST_AXD;
      ST_G0: begin
        mul_a = d0;
        mul_b = d0;
        state_next = ST_G1;
      end
      ST_G1: begin
        mul_a = d1;
        mul_b = d1;
        state_next = ST_G2;
      end
      ST_G2: begin
        mul_a = d2;
        mul_b = d2;
        state_next = ST_G3;
      end
      ST_G3: begin
        mul_a = $signed({16'd0, r_eff});
        mul_b = $signed({16'd0, r_eff});
        state_next = ST_G4;
      end
      ST_G4: state_next = ST_G5;
      ST_G5: begin
        if (dq == 64'd0 || dq >= rq) begin
          state_next = ST_FIN;
        end else begin
          itq.start  = 1'b1;
          itq.op     = OP_SQRT;
          itq.steps  = ANG_STEPS;
          itq.arg    = dq;
          state_next = ST_GY;
        end
      end
      ST_GY: if (itr.done) state_next = ST_GXS;
      ST_GXS: begin
        itq.start  = 1'b1;
        itq.op     = OP_SQRT;
        itq.steps  = ANG_STEPS;
        itq.arg    = rq - dq;
        state_next = ST_GX;
      end
      ST_GX: if (itr.done) state_next = ST_GN;
      ST_GN: if (gmx[33:29] == 5'd1) state_next = ST_CRD;
      ST_CRD: if (crd_i == 4'(CORDIC_STEPS - 1)) state_next = ST_GFIN;
      ST_GFIN: state_next = ST_FIN;
      ST_FIN: if (fin_go) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scr_w  <= 12'd1024;
      scr_h  <= 12'd768;
      radius <= 16'd4096;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        REG_WIDTH:  scr_w  <= cfg_data[11:0];
        REG_HEIGHT: scr_h  <= cfg_data[11:0];
        REG_RADIUS: radius <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed    <= 1'b0;
      ax       <= '0;
      ay       <= '0;
      az       <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == ST_FIN && fin_go) begin
        m_tvalid <= 1'b1;
        m_tuser  <= rv;
        m_tdata  <= {oang, oz, oy, ox};
        if (func_r == FN_PRESS) armed <= 1'b1;
        if (func_r == FN_RELEASE) armed <= 1'b0;
        if (func_r == FN_PRESS || func_r == FN_MOVE) begin
          ax <= bx;
          ay <= by;
          az <= bz;
        end
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        func_r <= s_tuser;
        cx_r   <= s_tdata[11:0];
        cy_r   <= s_tdata[23:12];
        rv     <= 1'b0;
        ox     <= '0;
        oy     <= '0;
        oz     <= '0;
        oang   <= '0;
        ai     <= '0;
      end
      ST_NX, ST_NY: neg_r <= nc_neg;
      ST_NXW: if (itr.done) bx <= neg_r ? -nq : nq;
      ST_NYW: if (itr.done) by <= neg_r ? nq : -nq;
      ST_N2B: acc <= prod;
      ST_N2C: acc <= acc + prod;
      ST_ZSPW: if (itr.done) bz <= {3'd0, itr.result[16:0]};
      ST_ZSHS: if (itr.done) sroot <= itr.result[31:0];
      ST_ZSHD: if (itr.done) bz <= {3'd0, itr.result[16:0]};
      ST_EVAL: if (func_r == FN_MOVE && armed) rv <= 1'b1;
      ST_C0B, ST_C1B, ST_C2B: acc <= prod;
      ST_C1A: c0 <= 36'(acc - prod);
      ST_C2A: c1 <= 36'(acc - prod);
      ST_C2C: c2 <= 36'(acc - prod);
      ST_DEG: begin
        m0 <= mg0;
        m1 <= mg1;
        m2 <= mg2;
        if (deg) begin
          ox <= AXIS_ONE;
          oy <= '0;
          oz <= '0;
        end
      end
      ST_NRM: begin
        if (mx[35:30] != '0) begin
          m0 <= m0 >> 1;
          m1 <= m1 >> 1;
          m2 <= m2 >> 1;
        end else if (!mx[29]) begin
          m0 <= m0 << 1;
          m1 <= m1 << 1;
          m2 <= m2 << 1;
        end
      end
      ST_SQ1, ST_G1: acc <= prod;
      ST_SQ2, ST_SQ3, ST_G2, ST_G3: acc <= acc + prod;
      ST_LENW: if (itr.done) len <= itr.result[31:0];
      ST_AXW: begin
        if (itr.done) begin
          case (ai)
            2'd0:    ox <= c0[35] ? -q16 : q16;
            2'd1:    oy <= c1[35] ? -q16 : q16;
            default: oz <= c2[35] ? -q16 : q16;
          endcase
          ai <= ai + 2'd1;
        end
      end
      ST_G4: begin
        dq <= acc << 2;
        rq <= prod << 8;
      end
      ST_G5: begin
        if (dq == 64'd0) oang <= '0;
        else if (dq >= rq) oang <= ANGLE_MAX;
      end
      ST_GY: if (itr.done) gy <= $signed({14'd0, itr.result[19:0]});
      ST_GX: begin
        if (itr.done) begin
          gx    <= $signed({14'd0, itr.result[19:0]});
          gz    <= '0;
          crd_i <= '0;
        end
      end
      ST_GN: begin
        if (gmx[33:30] != '0) begin
          gx <= gx >>> 1;
          gy <= gy >>> 1;
        end else if (!gmx[29]) begin
          gx <= gx <<< 1;
          gy <= gy <<< 1;
        end
      end
      ST_CRD: begin
        if (gy > 34'sd0) begin
          gx <= gx + ys;
          gy <= gy - xs;
          gz <= gz + atan_tab(crd_i);
        end else begin
          gx <= gx - ys;
          gy <= gy + xs;
          gz <= gz - atan_tab(crd_i);
        end
        crd_i <= crd_i + 4'd1;
      end
      ST_GFIN: oang <= (zr > {8'd0, ANGLE_MAX}) ? ANGLE_MAX : zr[15:0];
      default: ;
    endcase
  end

endmodule

### hdl/trk_mul.sv
// ----------------------------------------------------------------------------
// Trackball shared multiplier
// Signed 32x32 multiplier with a registered product.
// ----------------------------------------------------------------------------
module trk_mul import trk_pkg::*; (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

### hdl/trk_iter.sv
// ----------------------------------------------------------------------------
// Trackball iterative divide / square root unit
// Restoring division or bit-wise integer square root, one result bit a cycle.
// ----------------------------------------------------------------------------
module trk_iter import trk_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  it_req_t req,
  output it_rsp_t rsp
);

  logic [63:0] work;
  logic [63:0] res;
  logic [63:0] bitm;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [6:0]  cnt;
  it_op_t      op;
  logic        done;
  logic [32:0] rem_sh;
  logic [32:0] rem_dif;
  logic [63:0] sq_t;
  logic        sq_ge;

  assign rem_sh  = {rem, work[63]};
  assign rem_dif = rem_sh - {1'b0, dvs};
  assign sq_t    = res + bitm;
  assign sq_ge   = work >= sq_t;

  assign rsp.done   = done;
  assign rsp.result = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cnt != 7'd0) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) done <= 1'b1;
      end else if (req.start) begin
        cnt <= req.steps;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cnt == 7'd0 && req.start) begin
      op   <= req.op;
      dvs  <= req.divisor;
      rem  <= '0;
      res  <= '0;
      bitm <= 64'd1 << {req.steps - 7'd1, 1'b0};
      if (req.op == OP_DIV) work <= req.arg << (7'd64 - req.steps);
      else work <= req.arg;
    end else if (cnt != 7'd0) begin
      if (op == OP_DIV) begin
        work <= work << 1;
        if (!rem_dif[32]) begin
          rem <= rem_dif[31:0];
          res <= {res[62:0], 1'b1};
        end else begin
          rem <= rem_sh[31:0];
          res <= {res[62:0], 1'b0};
        end
      end else begin
        bitm <= bitm >> 2;
        if (sq_ge) begin
          work <= work - sq_t;
          res  <= (res >> 1) + bitm;
        end else begin
          res <= res >> 1;
        end
      end
    end
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trackball drag rotation testbench
// Drives pointer requests into the block under several window and radius
// settings; checks every result bit-exact to a predictor or a literal row.
// ----------------------------------------------------------------------------
module tb;
  import trk_pkg::*;

  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct {
    logic        rot;
    logic [63:0] data;
  } rot_t;

  typedef struct {
    logic [1:0]  fn;
    logic [11:0] cx;
    logic [11:0] cy;
    bit          lit;
    logic        rot;
    logic [63:0] data;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_addr = '0;
  logic [15:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;  // cursor_x [11:0], cursor_y [23:12]
  logic [1:0]  s_tuser = '0;  // func [1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;       // axis_x, axis_y, axis_z, angle_deg
  logic        m_tuser;       // rotation_valid [0]

  trackball_drag_rotation dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  rot_t   rot_q[$];
  int     errors = 0;
  longint cycles = 0;
  bit     idle_on = 1'b1;
  int     stall_left = 0;

  longint win_w, win_h, ball_r;
  bit     armed;
  longint last_p[3];

  function automatic longint isqrt(longint v);
    longint r, b;
    r = 0;
    b = 64'sh4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else r = r >> 1;
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint ndc(longint c, longint sz);
    longint diff, mag, q;
    if (sz == 0) sz = 1;
    diff = 2 * c - sz;
    mag = diff < 0 ? -diff : diff;
    q = (mag * (64'sd1 << FRAC_BITS) + sz / 2) / sz;
    if (q > (64'sd1 << (FRAC_BITS + 2)) - 1) q = (64'sd1 << (FRAC_BITS + 2)) - 1;
    return diff < 0 ? -q : q;
  endfunction

  function automatic longint rad();
    return ball_r == 0 ? 1 : ball_r;
  endfunction

  task automatic lift_point(input longint cx, input longint cy, output longint p[3]);
    longint r, x, y, n2, half, s;
    r = rad();
    x = ndc(cx, win_w);
    y = -ndc(cy, win_h);
    n2 = x * x + y * y;
    half = r << (2 * FRAC_BITS - 13);
    p[0] = x;
    p[1] = y;
    if (n2 < half) p[2] = isqrt((r << (2 * FRAC_BITS - 12)) - n2);
    else begin
      s = isqrt(n2);
      p[2] = (half + s / 2) / s;
    end
  endtask

  function automatic logic [47:0] axis_of(longint a[3], longint b[3]);
    longint c[3], mg[3], m, len, q;
    logic [47:0] o;
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
    m = 0;
    for (int i = 0; i < 3; i++) begin
      mg[i] = c[i] < 0 ? -c[i] : c[i];
      if (mg[i] > m) m = mg[i];
    end
    if (m < (64'sd1 << 31) && mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2] <= EPS_SUM)
      return {16'd0, 16'd0, AXIS_ONE};
    while (m >= (64'sd1 << 30)) begin
      for (int i = 0; i < 3; i++) mg[i] = mg[i] >> 1;
      m = m >> 1;
    end
    while (m < (64'sd1 << 29)) begin
      for (int i = 0; i < 3; i++) mg[i] = mg[i] << 1;
      m = m << 1;
    end
    len = isqrt(mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2]);
    for (int i = 0; i < 3; i++) begin
      q = ((mg[i] << 14) + len / 2) / len;
      if (c[i] < 0) q = -q;
      o[16*i +: 16] = q[15:0];
    end
    return o;
  endfunction

  function automatic logic [15:0] angle_of(longint a[3], longint b[3]);
    longint r, d2, dq, rq, x, y, z, m, xs, ys, d;
    r = rad();
    d2 = 0;
    z = 0;
    for (int i = 0; i < 3; i++) begin
      d = a[i] - b[i];
      d2 = d2 + d * d;
    end
    dq = d2 << 2;
    rq = (r * r) << (2 * FRAC_BITS - 20);
    if (dq == 0) return 16'd0;
    if (dq >= rq) return ANGLE_MAX;
    y = isqrt(dq);
    x = isqrt(rq - dq);
    m = x > y ? x : y;
    while (m >= (64'sd1 << 30)) begin
      x = x >>> 1; y = y >>> 1; m = m >> 1;
    end
    while (m < (64'sd1 << 29)) begin
      x = x <<< 1; y = y <<< 1; m = m << 1;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; z = z + atan_tab(i[3:0]);
      end else begin
        x = x - ys; y = y + xs; z = z - atan_tab(i[3:0]);
      end
    end
    if (z < 0) z = 0;
    if (z > ANGLE_LIM) z = ANGLE_LIM;
    m = (z * 2 + 128) >> 8;
    if (m > ANGLE_MAX) m = ANGLE_MAX;
    return m[15:0];
  endfunction

  task automatic predict_drag(input logic [1:0] fn, input longint cx, input longint cy,
                              output rot_t res);
    longint p[3];
    res.rot = 1'b0;
    res.data = '0;
    if (fn == FN_PRESS) begin
      lift_point(cx, cy, p);
      armed = 1'b1;
      last_p = p;
    end else if (fn == FN_RELEASE) begin
      armed = 1'b0;
    end else if (fn == FN_MOVE) begin
      lift_point(cx, cy, p);
      if (armed) begin
        res.rot = 1'b1;
        res.data = {angle_of(last_p, p), axis_of(last_p, p)};
      end
      last_p = p;
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_WIDTH:  win_w = val[11:0];
      REG_HEIGHT: win_h = val[11:0];
      REG_RADIUS: ball_r = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (rot_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  // hold the request until accepted; the caller runs at a falling edge
  task automatic send_req(input logic [1:0] fn, input logic [11:0] cx, input logic [11:0] cy,
                          input bit lit, input rot_t lit_res);
    rot_t res;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= {cy, cx};
    do @(posedge clk); while (!s_tready);
    predict_drag(fn, cx, cy, res);
    rot_q.push_back(lit ? lit_res : res);
    @(negedge clk);
  endtask

  task automatic idle_line();
    s_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [11:0] pick_coord(longint sz);
    longint lim;
    lim = sz < 1 ? 1 : sz;
    if ($urandom_range(0, 3) == 0) return 12'($urandom);
    return 12'($urandom_range(0, lim - 1));
  endfunction

  task automatic run_drags(input int n, input bit hold_mid);
    int sent, k;
    logic [11:0] cx, cy;
    rot_t none;
    none.rot = 1'b0;
    none.data = '0;
    sent = 0;
    while (sent < n) begin
      if (hold_mid && sent >= n / 2) begin
        idle_line();
        drain();
        hold_mid = 1'b0;
      end
      if ($urandom_range(0, 9) < 7) begin
        cx = pick_coord(win_w);
        cy = pick_coord(win_h);
        send_req(FN_PRESS, cx, cy, 1'b0, none);
        k = $urandom_range(1, 8);
        for (int i = 0; i < k; i++) begin
          if ($urandom_range(0, 5) == 0) begin
            cx = cx + 12'($urandom_range(0, 2)) - 12'd1;
          end else if ($urandom_range(0, 5) != 0) begin
            cx = pick_coord(win_w);
            cy = pick_coord(win_h);
          end
          send_req(FN_MOVE, cx, cy, 1'b0, none);
        end
        if ($urandom_range(0, 3) != 0) send_req(FN_RELEASE, 12'($urandom), 12'($urandom),
                                                1'b0, none);
        sent = sent + k + 2;
      end else begin
        send_req(2'($urandom), 12'($urandom), 12'($urandom), 1'b0, none);
        sent = sent + 1;
      end
    end
    idle_line();
  endtask

  task automatic set_view(input logic [15:0] w, input logic [15:0] h, input logic [15:0] r);
    drain();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_RADIUS, r);
  endtask

  row_t rows[] = '{
    '{FN_MOVE,    12'd512,  12'd384,  1'b1, 1'b0, 64'd0},
    '{FN_RELEASE, 12'd0,    12'd0,    1'b1, 1'b0, 64'd0},
    '{2'd3,       12'd4095, 12'd4095, 1'b1, 1'b0, 64'd0},
    '{FN_PRESS,   12'd512,  12'd384,  1'b1, 1'b0, 64'd0},
    '{FN_MOVE,    12'd512,  12'd384,  1'b1, 1'b1, {16'd0, 16'd0, 16'd0, AXIS_ONE}},
    '{FN_MOVE,    12'd600,  12'd384,  1'b0, 1'b0, 64'd0},
    '{FN_MOVE,    12'd600,  12'd300,  1'b0, 1'b0, 64'd0},
    '{FN_MOVE,    12'd0,    12'd0,    1'b0, 1'b0, 64'd0},
    '{FN_MOVE,    12'd1023, 12'd767,  1'b0, 1'b0, 64'd0},
    '{FN_MOVE,    12'd4095, 12'd4095, 1'b0, 1'b0, 64'd0},
    '{FN_MOVE,    12'd0,    12'd4095, 1'b0, 1'b0, 64'd0},
    '{2'd3,       12'd100,  12'd100,  1'b1, 1'b0, 64'd0},
    '{FN_MOVE,    12'd4095, 12'd0,    1'b0, 1'b0, 64'd0},
    '{FN_RELEASE, 12'd4095, 12'd4095, 1'b1, 1'b0, 64'd0},
    '{FN_RELEASE, 12'd1,    12'd2,    1'b1, 1'b0, 64'd0},
    '{FN_MOVE,    12'd10,   12'd20,   1'b1, 1'b0, 64'd0},
    '{FN_PRESS,   12'd0,    12'd0,    1'b1, 1'b0, 64'd0},
    '{FN_MOVE,    12'd1023, 12'd767,  1'b0, 1'b0, 64'd0},
    '{FN_MOVE,    12'd700,  12'd200,  1'b0, 1'b0, 64'd0},
    '{FN_PRESS,   12'd2730, 12'd1365, 1'b1, 1'b0, 64'd0},
    '{FN_MOVE,    12'd2730, 12'd1365, 1'b1, 1'b1, {16'd0, 16'd0, 16'd0, AXIS_ONE}},
    '{FN_MOVE,    12'd256,  12'd192,  1'b0, 1'b0, 64'd0}
  };

  initial begin
    rot_t lit_res;
    win_w = 1024;
    win_h = 768;
    ball_r = 4096;
    armed = 1'b0;
    last_p = '{0, 0, 0};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (rows[i]) begin
      lit_res.rot = rows[i].rot;
      lit_res.data = rows[i].data;
      send_req(rows[i].fn, rows[i].cx, rows[i].cy, rows[i].lit, lit_res);
    end
    idle_line();
    set_view(16'd1024, 16'd768, 16'd4096);
    run_drags(200, 1'b1);
    set_view(16'd1, 16'd1, 16'd1);
    run_drags(150, 1'b0);
    set_view(16'd4095, 16'd4095, 16'd65535);
    run_drags(200, 1'b0);
    set_view(16'd0, 16'd0, 16'd0);
    run_drags(150, 1'b0);
    set_view(16'd640, 16'd480, 16'd2048);
    run_drags(200, 1'b0);
    set_view(16'($urandom_range(1, 4095)), 16'($urandom_range(1, 4095)),
             16'($urandom_range(1, 65535)));
    run_drags(200, 1'b0);
    set_view(16'd1920, 16'd1080, 16'd3000);
    idle_on = 1'b0;
    run_drags(330, 1'b0);
    while (rot_q.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (errors == 0) $display("trackball_drag_rotation: match");
    else $display("trackball_drag_rotation: mismatch");
    $finish;
  end

  always @(negedge clk) begin
    if (!idle_on) m_tready <= 1'b1;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 9);
      m_tready <= 1'b0;
    end else m_tready <= 1'b1;
  end

  always @(posedge clk) begin
    rot_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("trackball_drag_rotation: mismatch");
      $finish;
    end
    if (!rst && m_tvalid && m_tready) begin
      if (rot_q.size() == 0) begin
        $error("unexpected result: rotation_valid %0d data %h", m_tuser, m_tdata);
        errors = errors + 1;
      end else begin
        want = rot_q.pop_front();
        if (m_tuser !== want.rot) begin
          $error("rotation_valid expected %0d actual %0d", want.rot, m_tuser);
          errors = errors + 1;
        end
        if (m_tdata[15:0] !== want.data[15:0]) begin
          $error("axis_x expected %0d actual %0d", $signed(want.data[15:0]),
                 $signed(m_tdata[15:0]));
          errors = errors + 1;
        end
        if (m_tdata[31:16] !== want.data[31:16]) begin
          $error("axis_y expected %0d actual %0d", $signed(want.data[31:16]),
                 $signed(m_tdata[31:16]));
          errors = errors + 1;
        end
        if (m_tdata[47:32] !== want.data[47:32]) begin
          $error("axis_z expected %0d actual %0d", $signed(want.data[47:32]),
                 $signed(m_tdata[47:32]));
          errors = errors + 1;
        end
        if (m_tdata[63:48] !== want.data[63:48]) begin
          $error("angle_deg expected %0d actual %0d", want.data[63:48], m_tdata[63:48]);
          errors = errors + 1;
        end
      end
    end
  end

endmodule
